// ----- design/first_fit_segment_allocator_top_defines.svh -----
// assertion macros for the segment allocator
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FFSA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ffsa check failed");
`define FFSA_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ffsa forbidden condition");
`else
`define FFSA_ASSERT(lbl, prop)
`define FFSA_NEVER(lbl, cond)
`endif
`endif

// ----- design/ffsa_pkg.sv -----
package ffsa_pkg;
	localparam int LOT_UNITS       = 1024;
	localparam int KEY_COUNT_DEF   = 1024;
	localparam int FREE_SLOTS_DEF  = 513;
	localparam int START_W         = 10;
	localparam int LEN_W           = 11;
	localparam int KEY_W           = 10;
	localparam int GRANT_W         = 16;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} seg_t;

	typedef struct packed {
		logic               valid;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} owner_t;
endpackage

// ----- design/ffsa_ram.sv -----
module ffsa_ram #(
	parameter int DEPTH = ffsa_pkg::FREE_SLOTS_DEF,
	parameter int WIDTH = $bits(ffsa_pkg::seg_t),
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import ffsa_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ----- design/first_fit_segment_allocator_top.sv -----
// first-fit segment allocator with a coalescing, address-ordered free list
// request channel: in_valid/in_ready with command, key, length; command 0
// allocates length units under key, command 1 releases the key's segment
// result channel: out_valid/out_ready with done_res, start_res and the
// saturating granted_count; one result per request, held until taken
// cfg_we/cfg_wdata set the space size and restart the space from empty
// one request at a time; in_ready is low from acceptance until the result
// is taken and rises on the next cycle. the free list sits in a ram walked
// one entry per cycle; an allocate walks it from the head up to the first entry
// that fits, a release up to the first entry above the freed segment; a segment
// used up, a merge of both sides or an insert of a new segment then moves each
// list entry behind it by one place, with a read and a write per entry
// a refused request or a release of an unknown key answers without a list walk
// after reset or a cfg write the owner table is cleared, one key per cycle,
// with in_ready low
// a stalled receiver holds the result and the block takes no new request
`include "first_fit_segment_allocator_top_defines.svh"
module first_fit_segment_allocator_top #(
	parameter int KEY_COUNT  = ffsa_pkg::KEY_COUNT_DEF,
	parameter int FREE_SLOTS = ffsa_pkg::FREE_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ffsa_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [ffsa_pkg::KEY_W-1:0]    key,
	input  logic [ffsa_pkg::LEN_W-1:0]    length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          done_res,
	output logic [ffsa_pkg::START_W-1:0]  start_res,
	output logic [ffsa_pkg::GRANT_W-1:0]  granted_count
);
	import ffsa_pkg::*;

	localparam int KW = $clog2(KEY_COUNT);
	localparam int FW = $clog2(FREE_SLOTS);
	localparam int CW = FW + 1;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ACHK  = 4'd2;
	localparam logic [3:0] S_OWN   = 4'd3;
	localparam logic [3:0] S_RCHK  = 4'd4;
	localparam logic [3:0] S_RDEC  = 4'd5;
	localparam logic [3:0] S_RMRD  = 4'd6;
	localparam logic [3:0] S_RMWR  = 4'd7;
	localparam logic [3:0] S_INRD  = 4'd8;
	localparam logic [3:0] S_INWR  = 4'd9;
	localparam logic [3:0] S_RESP  = 4'd10;

	logic [3:0]         state_q;
	logic [KW-1:0]      clr_q;
	logic [LEN_W-1:0]   lot_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      j_q;
	logic [GRANT_W-1:0] grants_q;
	logic               cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [LEN_W-1:0]   len_q;
	logic [START_W-1:0] s_q;
	logic [LEN_W-1:0]   l_q;
	seg_t               prev_q;
	seg_t               nxt_q;
	logic               has_prev_q;
	logic               above_q;
	logic               done_q;
	logic [START_W-1:0] start_q;

	logic [CW-1:0]    f_ra;
	logic             f_we;
	logic [CW-1:0]    f_wa;
	seg_t             f_wd;
	seg_t             f_rd;
	logic             o_we;
	logic [KW-1:0]    o_wa;
	logic [KW-1:0]    o_ra;
	owner_t           o_wd;
	owner_t           o_rd;

	logic             key_ok;
	logic             fit;
	logic             below;
	logic [LEN_W-1:0] s_end;
	logic [LEN_W-1:0] prev_end;
	logic [LEN_W-1:0] sat_lot;

	assign key_ok   = 32'(key) < KEY_COUNT;
	assign fit      = f_rd.len >= len_q;
	assign s_end    = LEN_W'(s_q) + l_q;
	assign prev_end = LEN_W'(prev_q.start) + prev_q.len;
	assign below    = has_prev_q && (prev_end == LEN_W'(s_q));
	assign sat_lot  = (cfg_wdata > LEN_W'(LOT_UNITS)) ? LEN_W'(LOT_UNITS) : cfg_wdata;

	assign in_ready      = state_q == S_IDLE;
	assign out_valid     = state_q == S_RESP;
	assign done_res      = done_q;
	assign start_res     = start_q;
	assign granted_count = grants_q;

	always_comb begin
		f_ra = '0;
		f_we = 1'b0;
		f_wa = '0;
		f_wd = '0;
		o_we = 1'b0;
		o_wa = KW'(key_q);
		o_wd = '0;
		o_ra = KW'(key);
		unique case (state_q)
			S_CLEAR: begin
				o_we = 1'b1;
				o_wa = clr_q;
				if (clr_q == '0) begin
					f_we = 1'b1;
					f_wd = '{start: '0, len: lot_q};
				end
			end
			S_ACHK: begin
				f_ra = idx_q + 1'b1;
				if (fit) begin
					o_we = 1'b1;
					o_wd = '{valid: 1'b1, start: f_rd.start, len: len_q};
					if (f_rd.len != len_q) begin
						f_we = 1'b1;
						f_wa = idx_q;
						f_wd = '{start: START_W'(LEN_W'(f_rd.start) + len_q),
							len: f_rd.len - len_q};
					end
				end
			end
			S_RCHK: f_ra = idx_q + 1'b1;
			S_RDEC: begin
				// valid mark drops unless a new entry is needed and the list is full
				o_we = below || above_q || (cnt_q < CW'(FREE_SLOTS));
				if (below) begin
					f_we = 1'b1;
					f_wa = idx_q - 1'b1;
					f_wd = '{start: prev_q.start,
						len: above_q ? (prev_q.len + l_q + nxt_q.len) : (prev_q.len + l_q)};
				end else if (above_q) begin
					f_we = 1'b1;
					f_wa = idx_q;
					f_wd = '{start: s_q, len: nxt_q.len + l_q};
				end
			end
			S_RMRD: f_ra = j_q + 1'b1;
			S_RMWR: begin
				f_we = 1'b1;
				f_wa = j_q;
				f_wd = f_rd;
			end
			S_INRD: begin
				f_ra = j_q - 1'b1;
				if (j_q == idx_q) begin
					f_we = 1'b1;
					f_wa = idx_q;
					f_wd = '{start: s_q, len: l_q};
				end
			end
			S_INWR: begin
				f_we = 1'b1;
				f_wa = j_q;
				f_wd = f_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			lot_q      <= LEN_W'(LOT_UNITS);
			cnt_q      <= CW'(1);
			grants_q   <= '0;
			idx_q      <= '0;
			j_q        <= '0;
			has_prev_q <= 1'b0;
			above_q    <= 1'b0;
			done_q     <= 1'b0;
			start_q    <= '0;
		end else if (cfg_we) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			lot_q    <= sat_lot;
			cnt_q    <= (sat_lot != '0) ? CW'(1) : '0;
			grants_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == KW'(KEY_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						done_q  <= 1'b0;
						start_q <= '0;
						idx_q   <= '0;
						if (!key_ok) begin
							state_q <= S_RESP;
						end else if (command == CMD_RELEASE) begin
							state_q <= S_OWN;
						end else if (length == '0 || cnt_q == '0) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_ACHK;
						end
					end
				end
				S_ACHK: begin
					if (fit) begin
						done_q  <= 1'b1;
						start_q <= f_rd.start;
						if (grants_q != '1) begin
							grants_q <= grants_q + 1'b1;
						end
						if (f_rd.len == len_q) begin
							j_q     <= idx_q;
							state_q <= S_RMRD;
						end else begin
							state_q <= S_RESP;
						end
					end else if (idx_q + 1'b1 < cnt_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_OWN: begin
					has_prev_q <= 1'b0;
					above_q    <= 1'b0;
					if (!o_rd.valid) begin
						state_q <= S_RESP;
					end else if (cnt_q == '0) begin
						state_q <= S_RDEC;
					end else begin
						state_q <= S_RCHK;
					end
				end
				S_RCHK: begin
					if (f_rd.start <= s_q) begin
						has_prev_q <= 1'b1;
						idx_q      <= idx_q + 1'b1;
						if (idx_q + 1'b1 >= cnt_q) begin
							state_q <= S_RDEC;
						end
					end else begin
						above_q <= LEN_W'(f_rd.start) == s_end;
						state_q <= S_RDEC;
					end
				end
				S_RDEC: begin
					if (below || above_q || cnt_q < CW'(FREE_SLOTS)) begin
						done_q  <= 1'b1;
						start_q <= s_q;
					end
					if (below && above_q) begin
						j_q     <= idx_q;
						state_q <= S_RMRD;
					end else if (below || above_q) begin
						state_q <= S_RESP;
					end else if (cnt_q < CW'(FREE_SLOTS)) begin
						j_q     <= cnt_q;
						state_q <= S_INRD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RMRD: begin
					if (j_q + 1'b1 < cnt_q) begin
						state_q <= S_RMWR;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_RMWR: begin
					j_q     <= j_q + 1'b1;
					state_q <= S_RMRD;
				end
				S_INRD: begin
					if (j_q == idx_q) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_INWR;
					end
				end
				S_INWR: begin
					j_q     <= j_q - 1'b1;
					state_q <= S_INRD;
				end
				S_RESP: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// request payload and release working values
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= command;
			key_q <= key;
			len_q <= length;
		end
		if (state_q == S_OWN) begin
			s_q <= o_rd.start;
			l_q <= o_rd.len;
		end
		if (state_q == S_RCHK) begin
			if (f_rd.start <= s_q) begin
				prev_q <= f_rd;
			end else begin
				nxt_q <= f_rd;
			end
		end
	end

	logic [$bits(seg_t)-1:0]   f_rd_raw;
	logic [$bits(owner_t)-1:0] o_rd_raw;
	assign f_rd = seg_t'(f_rd_raw);
	assign o_rd = owner_t'(o_rd_raw);

	ffsa_ram #(
		.DEPTH(FREE_SLOTS),
		.WIDTH($bits(seg_t))
	) u_free (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_wa[FW-1:0]),
		.wdata (f_wd),
		.raddr (f_ra[FW-1:0]),
		.rdata (f_rd_raw)
	);

	ffsa_ram #(
		.DEPTH(KEY_COUNT),
		.WIDTH($bits(owner_t))
	) u_owner (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_wa),
		.wdata (o_wd),
		.raddr (o_ra),
		.rdata (o_rd_raw)
	);

	`FFSA_NEVER(a_ready_vs_result, in_ready && out_valid)
	`FFSA_NEVER(a_free_count_max, cnt_q > CW'(FREE_SLOTS))
	`FFSA_ASSERT(a_clear_blocks, (state_q == S_CLEAR) |-> !in_ready)
	`FFSA_ASSERT(a_refused_start, (out_valid && !done_res) |-> (start_res == '0))
	`FFSA_ASSERT(a_grant_counted, ($rose(out_valid) && done_res && cmd_q == CMD_ALLOC) |-> (grants_q != '0))
endmodule
